FILE: rtl/core/pild_pkg.sv
// Package for the positional insert/delete list.
// Holds field widths, the default capacity, action and status codes and the sequencer states.
// No dependencies.
package pild_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ACTION_W   = 2;
  localparam int POSITION_W = 16;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL_CAP,
    ST_DEL,
    ST_RD_CAP,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/pild_if.sv
// Channel interfaces for the positional insert/delete list: request and response.
// Each carries valid, ready and the payload; depends on pild_pkg.
interface pild_req_if import pild_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [POSITION_W-1:0] position;
  logic signed [VALUE_W-1:0]    value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface pild_rsp_if import pild_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      clamped;
  logic signed [VALUE_W-1:0] data_out;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, status, clamped, data_out, count, input ready);
  modport sink   (input valid, status, clamped, data_out, count, output ready);
endinterface

FILE: rtl/core/pild_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module pild_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/positional_list_insert_delete_unit.sv
// Positional insert/delete list of signed 32-bit values, up to CAPACITY entries.
// Request channel (req): action, position, value. Response channel (rsp): status,
// clamped, data_out, count; one response for every request, in order.
// The entries live in one RAM with a registered read. An insert moves
// the entries from the end down to the insert point up by one, one entry a cycle
// (read one, write the previous one back), then writes the new value; a delete
// reads the victim and moves the entries behind it down the same way.
// One request is worked on at a time through the single RAM port pair, and req.ready
// is high while the sequencer is idle. A finished response waits in the output
// register; the next request may be taken meanwhile, and its response is held back
// until the waiting one is transferred.
// Reset (rst, synchronous) empties the list and drops any waiting response; the
// RAM is not cleared, as only entries below the count are ever read.
module positional_list_insert_delete_unit import pild_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic     clk,
  input logic     rst,
  pild_req_if.sink   req,
  pild_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW + 1 > POSITION_W + 1) ? CW + 1 : POSITION_W + 1;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] stop, stop_next;
  logic [CW-1:0] lim, lim_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic [VALUE_W-1:0] ins_val, ins_val_next;
  status_t       r_status, r_status_next;
  logic          r_clamped, r_clamped_next;
  logic [VALUE_W-1:0] r_data, r_data_next;

  logic          o_valid, o_valid_next;
  status_t       o_status, o_status_next;
  logic          o_clamped, o_clamped_next;
  logic [VALUE_W-1:0] o_data, o_data_next;
  logic [COUNT_W-1:0] o_count, o_count_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic signed [PW-1:0] pos_s, n_s;
  logic [CW-1:0] ins_p, del_p, idx_dec;
  logic          ins_cl, del_cl, rd_ok;

  pild_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Position clamping against the current count
  always_comb begin
    pos_s = {{(PW-POSITION_W){req.position[POSITION_W-1]}}, req.position};
    n_s   = {{(PW-CW){1'b0}}, count};
    if (pos_s < 0) begin
      ins_p  = '0;
      ins_cl = 1'b1;
    end else if (pos_s > n_s) begin
      ins_p  = count;
      ins_cl = 1'b1;
    end else begin
      ins_p  = pos_s[CW-1:0];
      ins_cl = 1'b0;
    end
    if (pos_s < 0) begin
      del_p  = '0;
      del_cl = 1'b1;
    end else if (pos_s >= n_s) begin
      del_p  = count - 1'b1;
      del_cl = 1'b1;
    end else begin
      del_p  = pos_s[CW-1:0];
      del_cl = 1'b0;
    end
    rd_ok   = (pos_s >= 0) && (pos_s < n_s);
    idx_dec = idx - 1'b1;
  end

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = o_valid;
  assign rsp.status   = o_status;
  assign rsp.clamped  = o_clamped;
  assign rsp.data_out = o_data;
  assign rsp.count    = o_count;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    stop_next      = stop;
    lim_next       = lim;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    ins_val_next   = ins_val;
    r_status_next  = r_status;
    r_clamped_next = r_clamped;
    r_data_next    = r_data;
    o_valid_next   = o_valid && !rsp.ready;
    o_status_next  = o_status;
    o_clamped_next = o_clamped;
    o_data_next    = o_data;
    o_count_next   = o_count;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          r_status_next  = STATUS_OK;
          r_clamped_next = 1'b0;
          r_data_next    = '0;
          pend_next      = 1'b0;
          case (action_t'(req.action))
            ACT_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                r_status_next = STATUS_FULL;
                state_next    = ST_DONE;
              end else begin
                stop_next      = ins_p;
                r_clamped_next = ins_cl;
                idx_next       = count;
                ins_val_next   = req.value;
                count_next     = count + 1'b1;
                state_next     = ST_INS;
              end
            end
            ACT_DELETE: begin
              if (count == '0) begin
                r_status_next = STATUS_EMPTY;
                state_next    = ST_DONE;
              end else begin
                ram_raddr      = del_p[AW-1:0];
                r_clamped_next = del_cl;
                idx_next       = del_p + 1'b1;
                lim_next       = count;
                count_next     = count - 1'b1;
                state_next     = ST_DEL_CAP;
              end
            end
            ACT_READ: begin
              if (rd_ok) begin
                ram_raddr  = pos_s[AW-1:0];
                state_next = ST_RD_CAP;
              end else begin
                r_status_next = STATUS_RANGE;
                state_next    = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_INS: begin
        // Move entry idx-1 up to idx, from the end down to the insert point
        if (idx != stop) begin
          if (pend) begin
            ram_we = 1'b1;
          end
          ram_raddr      = idx_dec[AW-1:0];
          pend_next      = 1'b1;
          pend_addr_next = idx[AW-1:0];
          idx_next       = idx_dec;
        end else if (pend) begin
          ram_we    = 1'b1;
          pend_next = 1'b0;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = stop[AW-1:0];
          ram_wdata  = ins_val;
          state_next = ST_DONE;
        end
      end

      ST_DEL_CAP, ST_DEL: begin
        if (state == ST_DEL_CAP) begin
          r_data_next = ram_rdata;
        end
        if (pend) begin
          ram_we = 1'b1;
        end
        // Move entry idx down to idx-1 until the old end is reached
        if (idx != lim) begin
          ram_raddr      = idx[AW-1:0];
          pend_next      = 1'b1;
          pend_addr_next = idx_dec[AW-1:0];
          idx_next       = idx + 1'b1;
          state_next     = ST_DEL;
        end else begin
          pend_next  = 1'b0;
          state_next = ST_DONE;
        end
      end

      ST_RD_CAP: begin
        r_data_next = ram_rdata;
        state_next  = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!o_valid || rsp.ready) begin
          o_valid_next   = 1'b1;
          o_status_next  = r_status;
          o_clamped_next = r_clamped;
          o_data_next    = r_data;
          o_count_next   = COUNT_W'(count);
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend    <= pend_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    stop      <= stop_next;
    lim       <= lim_next;
    pend_addr <= pend_addr_next;
    ins_val   <= ins_val_next;
    r_status  <= r_status_next;
    r_clamped <= r_clamped_next;
    r_data    <= r_data_next;
    o_status  <= o_status_next;
    o_clamped <= o_clamped_next;
    o_data    <= o_data_next;
    o_count   <= o_count_next;
  end

endmodule

FILE: sim/tb_positional_list_insert_delete_unit.sv
// Self-checking testbench for positional_list_insert_delete_unit: a directed table, then
// random fill/drain/mixed/read-heavy runs, each response checked against its table entry or a list model kept here.
// Depends on pild_pkg, pild_req_if and pild_rsp_if.
module tb_positional_list_insert_delete_unit import pild_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  LIST_DEPTH   = CAPACITY_DEF;
  localparam int                  RANDOM_ITEMS = 1730;
  localparam int                  MAX_CYCLES   = 1_000_000;
  localparam int                  DRAIN_WAIT   = LIST_DEPTH + 20;
  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

  typedef struct {
    status_t                   status;
    logic                      clamped;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
  } outcome_t;

  typedef struct {
    logic [ACTION_W-1:0]          act;
    logic signed [POSITION_W-1:0] pos;
    logic signed [VALUE_W-1:0]    val;
    bit                           known;
    outcome_t                     typed;
  } row_t;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIX, BIAS_READS} bias_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pild_req_if req_ch ();
  pild_rsp_if rsp_ch ();

  positional_list_insert_delete_unit #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [VALUE_W-1:0] list_entries [LIST_DEPTH];
  int                        list_count = 0;
  outcome_t                  pending_outcomes [$];
  row_t                      directed_rows [$];
  int                        errors = 0;
  int                        cycle_count = 0;
  bit                        no_idle = 1'b0;

  // Apply one operation to the list model and return what the block must answer.
  function automatic outcome_t list_apply(logic [ACTION_W-1:0] act,
                                          logic signed [POSITION_W-1:0] pos,
                                          logic signed [VALUE_W-1:0] val);
    outcome_t o;
    int       p;
    int       n;
    o.status  = STATUS_OK;
    o.clamped = 1'b0;
    o.data    = '0;
    n = list_count;
    p = pos;
    case (act)
      ACT_INSERT: begin
        if (n >= LIST_DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          if (p < 0) begin
            p = 0;
            o.clamped = 1'b1;
          end else if (p > n) begin
            p = n;
            o.clamped = 1'b1;
          end
          for (int i = n; i > p; i--) list_entries[i] = list_entries[i-1];
          list_entries[p] = val;
          list_count++;
        end
      end
      ACT_DELETE: begin
        if (n == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          if (p < 0) begin
            p = 0;
            o.clamped = 1'b1;
          end else if (p >= n) begin
            p = n - 1;
            o.clamped = 1'b1;
          end
          o.data = list_entries[p];
          for (int i = p; i < n - 1; i++) list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      ACT_READ: begin
        if (p < 0 || p >= n) o.status = STATUS_RANGE;
        else o.data = list_entries[p];
      end
      default: ;
    endcase
    o.count = COUNT_W'(list_count);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly legal positions, with the edges, just outside, and the whole 16-bit range.
  function automatic logic signed [POSITION_W-1:0] pick_position(int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return (hi < 0) ? '0 : POSITION_W'($urandom_range(0, hi));
    if (r < 15) return POSITION_W'(hi + 1);
    if (r < 16) return -16'sd1;
    if (r < 18) return POSITION_W'($urandom);
    return (r == 18) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(bias_t bias);
    int r;
    int ins_lim;
    int del_lim;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin ins_lim = 80; del_lim = 90; end
      BIAS_DRAIN: begin ins_lim = 20; del_lim = 85; end
      BIAS_MIX:   begin ins_lim = 40; del_lim = 75; end
      default:    begin ins_lim = 20; del_lim = 35; end
    endcase
    if (r < 3) return ACT_UNUSED;
    if (r < ins_lim) return ACT_INSERT;
    if (r < del_lim) return ACT_DELETE;
    return ACT_READ;
  endfunction

  task automatic add_row(logic [ACTION_W-1:0] act, logic signed [POSITION_W-1:0] pos,
                         logic signed [VALUE_W-1:0] val, bit known = 1'b0,
                         status_t st = STATUS_OK, logic cl = 1'b0,
                         logic signed [VALUE_W-1:0] d = '0, logic [COUNT_W-1:0] c = '0);
    row_t row;
    row.act           = act;
    row.pos           = pos;
    row.val           = val;
    row.known         = known;
    row.typed.status  = st;
    row.typed.clamped = cl;
    row.typed.data    = d;
    row.typed.count   = c;
    directed_rows.push_back(row);
  endtask

  // Present one request and hold it until the transfer; the model is advanced on acceptance.
  task automatic send_request(row_t row);
    int       gap;
    outcome_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.action   = row.act;
    req_ch.position = row.pos;
    req_ch.value    = row.val;
    req_ch.valid    = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = list_apply(row.act, row.pos, row.val);
    pending_outcomes.push_back(row.known ? row.typed : predicted);
  endtask

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.action   = '0;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
  end

  // Response side: ready with random stalls, none while no_idle is set.
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left > 0 && !no_idle) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall_left = pick_gap();
      end
      @(negedge clk);
    end
  end

  outcome_t want_out;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: response with none expected (status %0d, data %0d, count %0d)",
                 $time, rsp_ch.status, rsp_ch.data_out, rsp_ch.count);
      end else begin
        want_out = pending_outcomes.pop_front();
        check_field("status", want_out.status, rsp_ch.status);
        check_field("clamped", want_out.clamped, rsp_ch.clamped);
        check_field("data_out", want_out.data, rsp_ch.data_out);
        check_field("count", want_out.count, rsp_ch.count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t  row;
    bias_t bias;
    int    sent;
    int    run_len;
    int    runs;

    // Empty list: delete and read both refused, unused action leaves everything alone.
    add_row(ACT_DELETE, 16'sd0, 32'sd0, 1'b1, STATUS_EMPTY, 1'b0, 32'sd0, 7'd0);
    add_row(ACT_READ, 16'sd0, 32'sd0, 1'b1, STATUS_RANGE, 1'b0, 32'sd0, 7'd0);
    add_row(ACT_UNUSED, -16'sd1, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 1'b0, 32'sd0, 7'd0);
    // Insert into empty at a non-zero position is clamped; then both extremes of position.
    add_row(ACT_INSERT, 16'sd5, 32'h7FFF_FFFF, 1'b1, STATUS_OK, 1'b1, 32'sd0, 7'd1);
    add_row(ACT_INSERT, 16'sh8000, 32'h8000_0000, 1'b1, STATUS_OK, 1'b1, 32'sd0, 7'd2);
    add_row(ACT_INSERT, 16'sh7FFF, -32'sd1, 1'b1, STATUS_OK, 1'b1, 32'sd0, 7'd3);
    add_row(ACT_INSERT, 16'sd1, 32'sd0);
    add_row(ACT_INSERT, 16'sd4, 32'h5A5A_A5A5);
    add_row(ACT_INSERT, 16'sd0, 32'sd1);
    add_row(ACT_READ, -16'sd1, 32'sd0, 1'b1, STATUS_RANGE, 1'b0, 32'sd0, 7'd6);
    add_row(ACT_READ, 16'sd6, 32'sd0, 1'b1, STATUS_RANGE, 1'b0, 32'sd0, 7'd6);
    add_row(ACT_READ, 16'sh7FFF, 32'sd0, 1'b1, STATUS_RANGE, 1'b0, 32'sd0, 7'd6);
    add_row(ACT_READ, 16'sd0, 32'sd0);
    add_row(ACT_READ, 16'sd5, 32'sd0);
    // Delete clamping at both ends, then at exactly the count.
    add_row(ACT_DELETE, 16'sh8000, 32'sd0);
    add_row(ACT_DELETE, 16'sh7FFF, 32'sd0);
    add_row(ACT_DELETE, 16'sd4, 32'sd0);
    add_row(ACT_DELETE, 16'sd1, 32'sd0);
    add_row(ACT_UNUSED, 16'sh7FFF, 32'h7FFF_FFFF, 1'b1, STATUS_OK, 1'b0, 32'sd0, 7'd2);
    add_row(ACT_DELETE, 16'sd0, 32'sd0);
    add_row(ACT_DELETE, 16'sd0, 32'sd0);
    add_row(ACT_INSERT, 16'sd0, 32'sd123, 1'b1, STATUS_OK, 1'b0, 32'sd0, 7'd1);
    add_row(ACT_DELETE, 16'sd0, 32'sd0, 1'b1, STATUS_OK, 1'b0, 32'sd123, 7'd0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random runs: fill and drain walk the count between empty and full.
    sent = 0;
    runs = 0;
    row.known = 1'b0;
    row.typed = '{STATUS_OK, 1'b0, '0, '0};
    while (sent < RANDOM_ITEMS) begin
      bias    = bias_t'($urandom_range(0, 3));
      run_len = $urandom_range(40, 160);
      no_idle = ($urandom_range(0, 3) == 0);
      if (runs == 0 || $urandom_range(0, 4) == 0) begin
        // hold off until every outstanding response is back
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        row.act = pick_action(bias);
        row.pos = pick_position((row.act == ACT_INSERT) ? list_count : list_count - 1);
        row.val = VALUE_W'($urandom);
        send_request(row);
        sent++;
      end
      runs++;
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    no_idle = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
